// ===== hdl/irfs_pkg.sv =====
// irfs_pkg: shared types and constants of the infrared remote frame sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package irfs_pkg;

	localparam int unsigned ADDR_WIDTH = 5;
	localparam int unsigned DATA_WIDTH = 32;

	localparam logic [2:0] REG_START_TIMING  = 3'd0;
	localparam logic [2:0] REG_ONE_TIMING    = 3'd1;
	localparam logic [2:0] REG_ZERO_TIMING   = 3'd2;
	localparam logic [2:0] REG_REPEAT_TIMING = 3'd3;
	localparam logic [2:0] REG_REPEAT_TIME   = 3'd4;
	localparam logic [2:0] REG_FRAME_FORMAT  = 3'd5;
	localparam logic [2:0] REG_NO_STOP_BIT   = 3'd6;

	localparam logic OP_START = 1'b0;
	localparam logic OP_CYCLE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] first_word;
		logic [31:0] second_word;
	} item_t;

	typedef struct packed {
		logic [15:0] mark_ticks;
		logic [15:0] space_ticks;
		logic        extended_space;
		logic        carrier_stop;
		logic        busy_res;
	} result_t;

	typedef struct packed {
		logic [31:0] start_timing;
		logic [31:0] one_timing;
		logic [31:0] zero_timing;
		logic [31:0] repeat_timing;
		logic [31:0] repeat_time;
		logic [21:0] frame_format;
		logic        no_stop_bit;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/ir_remote_frame_sequencer.sv =====
// ir_remote_frame_sequencer: top level with input and result registers
// depends on irfs_pkg, irfs_regs, irfs_core
//
// Sequences an infrared remote frame as mark/space intervals. A start request
// loads both data words and answers with the start-bit periods; every
// end-of-cycle request answers with the periods of the next interval. Each
// request gives exactly one result. One request is taken per clock while the
// result side does not stall; a request is held in the input register, its
// result is formed by the frame state machine from that register and held in
// the result register, so the rate is set by the next-state logic. The user
// must write timing registers through the apb port only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module ir_remote_frame_sequencer #(
	parameter int unsigned TICK_WIDTH = 16,
	parameter int unsigned WORD_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire irfs_pkg::item_t                 item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output irfs_pkg::result_t                    result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [irfs_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [irfs_pkg::DATA_WIDTH-1:0] pwdata,
	output logic      [irfs_pkg::DATA_WIDTH-1:0] prdata,
	output logic                                 pready
);
	import irfs_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t core_result;
	result_t result_q;
	logic    result_valid_q;
	logic    advance;
	logic    accept;

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall   = valid_s1 && result_valid_q && result_stall;
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	irfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	irfs_core #(
		.TICK_WIDTH (TICK_WIDTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= core_result;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/irfs_regs.sv =====
// irfs_regs: apb-style configuration register file
// depends on irfs_pkg
`default_nettype none

module irfs_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [irfs_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [irfs_pkg::DATA_WIDTH-1:0] pwdata,
	output logic      [irfs_pkg::DATA_WIDTH-1:0] prdata,
	output logic                                 pready,
	output irfs_pkg::cfg_t                       cfg
);
	import irfs_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_TIMING:  cfg_q.start_timing  <= pwdata;
				REG_ONE_TIMING:    cfg_q.one_timing    <= pwdata;
				REG_ZERO_TIMING:   cfg_q.zero_timing   <= pwdata;
				REG_REPEAT_TIMING: cfg_q.repeat_timing <= pwdata;
				REG_REPEAT_TIME:   cfg_q.repeat_time   <= pwdata;
				REG_FRAME_FORMAT:  cfg_q.frame_format  <= pwdata[21:0];
				REG_NO_STOP_BIT:   cfg_q.no_stop_bit   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_TIMING:  prdata = cfg_q.start_timing;
			REG_ONE_TIMING:    prdata = cfg_q.one_timing;
			REG_ZERO_TIMING:   prdata = cfg_q.zero_timing;
			REG_REPEAT_TIMING: prdata = cfg_q.repeat_timing;
			REG_REPEAT_TIME:   prdata = cfg_q.repeat_time;
			REG_FRAME_FORMAT:  prdata = {10'd0, cfg_q.frame_format};
			REG_NO_STOP_BIT:   prdata = {31'd0, cfg_q.no_stop_bit};
			default:           prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/irfs_core.sv =====
// irfs_core: frame state machine and next-interval logic for one request
// depends on irfs_pkg
`default_nettype none

module irfs_core #(
	parameter int unsigned TICK_WIDTH = 16,
	parameter int unsigned WORD_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire irfs_pkg::item_t item,
	input  wire irfs_pkg::cfg_t  cfg,
	output irfs_pkg::result_t    result
);
	import irfs_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_INITIAL,
		PH_START,
		PH_FIRST,
		PH_MIDDLE,
		PH_SECOND,
		PH_STOP,
		PH_TRAILER
	} phase_t;

	localparam int unsigned HALF_WIDTH = 31;

	phase_t                  phase_q, phase_n, ph_a;
	logic [6:0]              rep_cnt_q, rep_cnt_n, rep_cnt_a, rep_inc;
	logic [6:0]              bit_cnt_q, bit_cnt_n, bit_cnt_a;
	logic [WORD_WIDTH-1:0]   shift_q, shift_n, shift_a;
	logic [31:0]             elapsed_q, elapsed_n, elapsed_a;
	logic [WORD_WIDTH-1:0]   held_first_q, held_first_n;
	logic [WORD_WIDTH-1:0]   held_second_q, held_second_n;
	logic                    busy_q, busy_n;

	logic [6:0]              pkt_len, mid_idx, reps;
	logic                    fast;
	logic [TICK_WIDTH-1:0]   start_m, start_s, one_m, one_s, zero_m, zero_s;
	logic [TICK_WIDTH-1:0]   rpt_m, rpt_s, bit_m, bit_s, half_sat;
	logic [TICK_WIDTH:0]     start_sum, bit_sum, mid_sum, stop_sum;
	logic [31:0]             remain;
	logic [HALF_WIDTH-1:0]   half;

	assign pkt_len = cfg.frame_format[6:0];
	assign mid_idx = cfg.frame_format[13:7];
	assign reps    = cfg.frame_format[20:14];
	assign fast    = cfg.frame_format[21];

	assign start_m = cfg.start_timing[16 +: TICK_WIDTH];
	assign start_s = cfg.start_timing[0 +: TICK_WIDTH];
	assign one_m   = cfg.one_timing[16 +: TICK_WIDTH];
	assign one_s   = cfg.one_timing[0 +: TICK_WIDTH];
	assign zero_m  = cfg.zero_timing[16 +: TICK_WIDTH];
	assign zero_s  = cfg.zero_timing[0 +: TICK_WIDTH];
	assign rpt_m   = cfg.repeat_timing[16 +: TICK_WIDTH];
	assign rpt_s   = cfg.repeat_timing[0 +: TICK_WIDTH];

	assign start_sum = {1'b0, start_m} + {1'b0, start_s};
	assign mid_sum   = {1'b0, one_m} + {1'b0, start_s};
	assign stop_sum  = {1'b0, zero_m} + {1'b0, zero_s};
	assign bit_m     = shift_a[0] ? one_m : zero_m;
	assign bit_s     = shift_a[0] ? one_s : zero_s;
	assign bit_sum   = {1'b0, bit_m} + {1'b0, bit_s};
	assign rep_inc   = rep_cnt_q + 7'd1;

	// trailer halves from the time left in the packet, saturated
	assign remain   = cfg.repeat_time - elapsed_q;
	assign half     = (cfg.repeat_time > elapsed_q) ? remain[31:1] : '0;
	assign half_sat = ((half >> TICK_WIDTH) != '0) ? '1 : half[TICK_WIDTH-1:0];

	always_comb begin
		phase_n       = phase_q;
		rep_cnt_n     = rep_cnt_q;
		bit_cnt_n     = bit_cnt_q;
		shift_n       = shift_q;
		elapsed_n     = elapsed_q;
		held_first_n  = held_first_q;
		held_second_n = held_second_q;
		busy_n        = busy_q;
		result        = '0;
		ph_a          = phase_q;
		rep_cnt_a     = (phase_q == PH_INITIAL) ? 7'd0 : rep_cnt_q;
		bit_cnt_a     = bit_cnt_q;
		shift_a       = shift_q;
		elapsed_a     = elapsed_q;

		// advance from the interval just finished
		case (phase_q)
			PH_INITIAL, PH_START: begin
				bit_cnt_a = '0;
				shift_a   = held_first_q;
				elapsed_a = 32'(start_sum);
				if (rep_cnt_a != 7'd0 && fast) begin
					bit_cnt_a = pkt_len;
					ph_a      = PH_STOP;
				end else if (mid_idx == 7'd0) begin
					ph_a = PH_SECOND;
				end else begin
					ph_a = PH_FIRST;
				end
			end
			PH_FIRST: begin
				if (bit_cnt_q == mid_idx) ph_a = PH_MIDDLE;
			end
			PH_MIDDLE: begin
				ph_a    = PH_SECOND;
				shift_a = held_second_q;
			end
			PH_SECOND: begin
				if (bit_cnt_q == pkt_len) ph_a = cfg.no_stop_bit ? PH_TRAILER : PH_STOP;
			end
			PH_STOP: ph_a = PH_TRAILER;
			default: ;
		endcase

		if (item.op == OP_START) begin
			held_first_n       = item.first_word[WORD_WIDTH-1:0];
			held_second_n      = item.second_word[WORD_WIDTH-1:0];
			busy_n             = 1'b1;
			elapsed_n          = '0;
			phase_n            = PH_INITIAL;
			result.mark_ticks  = 16'(start_m);
			result.space_ticks = 16'(start_s);
			result.busy_res    = 1'b1;
		end else if (phase_q == PH_IDLE) begin
			result = '0;
		end else if (phase_q == PH_TRAILER) begin
			// packet complete
			rep_cnt_n = rep_inc;
			if (rep_inc >= reps) begin
				phase_n             = PH_IDLE;
				busy_n              = 1'b0;
				result.mark_ticks   = 16'(start_m);
				result.space_ticks  = 16'(start_s);
				result.carrier_stop = 1'b1;
				result.busy_res     = 1'b0;
			end else begin
				phase_n            = PH_START;
				result.mark_ticks  = 16'(rpt_m);
				result.space_ticks = 16'(rpt_s);
				result.busy_res    = busy_q;
			end
		end else begin
			phase_n         = ph_a;
			rep_cnt_n       = rep_cnt_a;
			bit_cnt_n       = bit_cnt_a;
			shift_n         = shift_a;
			elapsed_n       = elapsed_a;
			result.busy_res = busy_q;
			case (ph_a)
				PH_FIRST, PH_SECOND: begin
					result.mark_ticks  = 16'(bit_m);
					result.space_ticks = 16'(bit_s);
					elapsed_n          = elapsed_a + 32'(bit_sum);
					bit_cnt_n          = bit_cnt_a + 7'd1;
					shift_n            = shift_a >> 1;
				end
				PH_MIDDLE: begin
					result.mark_ticks  = 16'(one_m);
					result.space_ticks = 16'(start_s);
					elapsed_n          = elapsed_a + 32'(mid_sum);
				end
				PH_STOP: begin
					result.mark_ticks  = 16'(zero_m);
					result.space_ticks = 16'(zero_s);
					elapsed_n          = elapsed_a + 32'(stop_sum);
				end
				default: begin
					result.mark_ticks     = 16'(half_sat);
					result.space_ticks    = 16'(half_sat);
					result.extended_space = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			rep_cnt_q     <= '0;
			bit_cnt_q     <= '0;
			shift_q       <= '0;
			elapsed_q     <= '0;
			held_first_q  <= '0;
			held_second_q <= '0;
			busy_q        <= 1'b0;
		end else if (fire) begin
			phase_q       <= phase_n;
			rep_cnt_q     <= rep_cnt_n;
			bit_cnt_q     <= bit_cnt_n;
			shift_q       <= shift_n;
			elapsed_q     <= elapsed_n;
			held_first_q  <= held_first_n;
			held_second_q <= held_second_n;
			busy_q        <= busy_n;
		end
	end

endmodule

`default_nettype wire

// ===== test/ir_remote_frame_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ir_remote_frame_sequencer_tb: self-checking bench for the ir frame sequencer
// depends on irfs_pkg and ir_remote_frame_sequencer; predicts every interval
// from its own copy of the frame state and checks each result in order
module ir_remote_frame_sequencer_tb;
	import irfs_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_LEAD, SEQ_HEADER, SEQ_WORD_A, SEQ_MID, SEQ_WORD_B, SEQ_STOP, SEQ_TRAIL
	} seq_phase_t;

	localparam int unsigned CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr = '0;
	logic [DATA_WIDTH-1:0] pwdata = '0;
	logic [DATA_WIDTH-1:0] prdata;
	logic pready;

	// predictor state and register copy
	cfg_t frame_cfg = '0;
	seq_phase_t seq_phase = SEQ_IDLE;
	logic [6:0] packets_sent = '0;
	logic [6:0] bits_sent = '0;
	logic [31:0] data_shift = '0;
	logic [31:0] ticks_used = '0;
	logic [31:0] word_lo = '0;
	logic [31:0] word_hi = '0;
	logic seq_busy = 1'b0;

	item_t pending_requests[$];
	result_t expected_intervals[$];

	logic req_taken = 1'b0;
	logic res_taken = 1'b0;
	logic send_quiet = 1'b0;
	logic recv_quiet = 1'b0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned n_req = 0;
	int unsigned n_res = 0;
	int unsigned n_settings = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	ir_remote_frame_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t next_interval(input item_t it);
		logic [6:0] len;
		logic [6:0] mid;
		logic [6:0] reps;
		logic fast;
		logic [31:0] pick;
		logic [31:0] diff;
		result_t r;
		len = frame_cfg.frame_format[6:0];
		mid = frame_cfg.frame_format[13:7];
		reps = frame_cfg.frame_format[20:14];
		fast = frame_cfg.frame_format[21];
		r = '0;
		if (it.op == OP_START) begin
			word_lo = it.first_word;
			word_hi = it.second_word;
			seq_busy = 1'b1;
			ticks_used = '0;
			seq_phase = SEQ_LEAD;
			r.mark_ticks = frame_cfg.start_timing[31:16];
			r.space_ticks = frame_cfg.start_timing[15:0];
			r.busy_res = 1'b1;
			return r;
		end
		if (seq_phase == SEQ_IDLE)
			return r;
		case (seq_phase)
			SEQ_LEAD, SEQ_HEADER: begin
				if (seq_phase == SEQ_LEAD)
					packets_sent = '0;
				bits_sent = '0;
				data_shift = word_lo;
				ticks_used = frame_cfg.start_timing[31:16] + frame_cfg.start_timing[15:0];
				if (packets_sent != 0 && fast) begin
					bits_sent = len;
					seq_phase = SEQ_STOP;
				end else if (mid == 0) begin
					seq_phase = SEQ_WORD_B;
				end else begin
					seq_phase = SEQ_WORD_A;
				end
			end
			SEQ_WORD_A: if (bits_sent == mid) seq_phase = SEQ_MID;
			SEQ_MID: begin
				seq_phase = SEQ_WORD_B;
				data_shift = word_hi;
			end
			SEQ_WORD_B: if (bits_sent == len) begin
				seq_phase = frame_cfg.no_stop_bit ? SEQ_TRAIL : SEQ_STOP;
			end
			SEQ_STOP: seq_phase = SEQ_TRAIL;
			default: begin
				packets_sent = packets_sent + 7'd1;
				if (packets_sent >= reps) begin
					seq_phase = SEQ_IDLE;
					seq_busy = 1'b0;
					r.mark_ticks = frame_cfg.start_timing[31:16];
					r.space_ticks = frame_cfg.start_timing[15:0];
					r.carrier_stop = 1'b1;
				end else begin
					seq_phase = SEQ_HEADER;
					r.mark_ticks = frame_cfg.repeat_timing[31:16];
					r.space_ticks = frame_cfg.repeat_timing[15:0];
				end
				r.busy_res = seq_busy;
				return r;
			end
		endcase
		r.busy_res = seq_busy;
		case (seq_phase)
			SEQ_WORD_A, SEQ_WORD_B: begin
				pick = data_shift[0] ? frame_cfg.one_timing : frame_cfg.zero_timing;
				r.mark_ticks = pick[31:16];
				r.space_ticks = pick[15:0];
				bits_sent = bits_sent + 7'd1;
				data_shift = data_shift >> 1;
			end
			SEQ_MID: begin
				r.mark_ticks = frame_cfg.one_timing[31:16];
				r.space_ticks = frame_cfg.start_timing[15:0];
			end
			SEQ_STOP: begin
				r.mark_ticks = frame_cfg.zero_timing[31:16];
				r.space_ticks = frame_cfg.zero_timing[15:0];
			end
			default: begin
				r.extended_space = 1'b1;
				if (frame_cfg.repeat_time > ticks_used) begin
					diff = (frame_cfg.repeat_time - ticks_used) >> 1;
					r.mark_ticks = (diff > 32'h0000_FFFF) ? 16'hFFFF : diff[15:0];
					r.space_ticks = r.mark_ticks;
				end
			end
		endcase
		if (!r.extended_space)
			ticks_used = ticks_used + r.mark_ticks + r.space_ticks;
		return r;
	endfunction

	function automatic logic [31:0] draw_timing();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return {16'($urandom_range(0, 255)), 16'($urandom_range(0, 255))};
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return {16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000))};
		endcase
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_START_TIMING: frame_cfg.start_timing = val;
			REG_ONE_TIMING: frame_cfg.one_timing = val;
			REG_ZERO_TIMING: frame_cfg.zero_timing = val;
			REG_REPEAT_TIMING: frame_cfg.repeat_timing = val;
			REG_REPEAT_TIME: frame_cfg.repeat_time = val;
			REG_FRAME_FORMAT: frame_cfg.frame_format = val[21:0];
			REG_NO_STOP_BIT: frame_cfg.no_stop_bit = val[0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic program_regs(input cfg_t c);
		reg_write(REG_START_TIMING, c.start_timing);
		reg_write(REG_ONE_TIMING, c.one_timing);
		reg_write(REG_ZERO_TIMING, c.zero_timing);
		reg_write(REG_REPEAT_TIMING, c.repeat_timing);
		reg_write(REG_REPEAT_TIME, c.repeat_time);
		reg_write(REG_FRAME_FORMAT, {10'd0, c.frame_format});
		reg_write(REG_NO_STOP_BIT, {31'd0, c.no_stop_bit});
		n_settings++;
	endtask

	task automatic queue_start(input logic [31:0] a, input logic [31:0] b);
		item_t it;
		it.op = OP_START;
		it.first_word = a;
		it.second_word = b;
		pending_requests.push_back(it);
	endtask

	task automatic queue_cycles(input int unsigned n);
		item_t it;
		repeat (n) begin
			it.op = OP_CYCLE;
			it.first_word = $urandom;
			it.second_word = $urandom;
			pending_requests.push_back(it);
		end
	endtask

	task automatic queue_noise();
		item_t it;
		it.op = 1'($urandom_range(0, 1));
		it.first_word = $urandom;
		it.second_word = $urandom;
		pending_requests.push_back(it);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_requests.size() != 0 || item_valid || expected_intervals.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// request side
	always @(posedge clk) begin
		req_taken <= arst_n && item_valid && !item_stall;
		if (arst_n && item_valid && !item_stall) begin
			expected_intervals.push_back(next_interval(item));
			n_req++;
		end
	end

	always @(negedge clk) begin : drive
		logic nv;
		item_t ni;
		nv = item_valid;
		ni = item;
		if (!arst_n) begin
			nv = 1'b0;
		end else begin
			if (nv && req_taken)
				nv = 1'b0;
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_requests.size() > 0) begin
					ni = pending_requests.pop_front();
					nv = 1'b1;
					send_gap = send_quiet ? 0 : $urandom_range(0, 6);
				end
			end
		end
		item_valid <= nv;
		item <= ni;
	end

	// result side
	always @(negedge clk) begin
		if (res_taken)
			recv_gap = recv_quiet ? 0 : $urandom_range(0, 6);
		if (recv_gap > 0) begin
			result_stall <= 1'b1;
			recv_gap--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		res_taken <= arst_n && result_valid && !result_stall;
		if (arst_n && result_valid && !result_stall) begin
			n_res++;
			if (expected_intervals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no request outstanding", n_res);
			end else begin
				want = expected_intervals.pop_front();
				if (result.mark_ticks !== want.mark_ticks ||
					result.space_ticks !== want.space_ticks ||
					result.extended_space !== want.extended_space ||
					result.carrier_stop !== want.carrier_stop ||
					result.busy_res !== want.busy_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected mark %0d space %0d ext %0b stop %0b busy %0b, %s",
							n_res, want.mark_ticks, want.space_ticks, want.extended_space,
							want.carrier_stop, want.busy_res,
							$sformatf("got mark %0d space %0d ext %0b stop %0b busy %0b",
								result.mark_ticks, result.space_ticks, result.extended_space,
								result.carrier_stop, result.busy_res));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("ir_remote_frame_sequencer_tb failed");
			$finish;
		end
	end

	initial begin
		cfg_t c;
		int unsigned len;
		int unsigned mid;
		int unsigned reps;
		int unsigned pk;
		int unsigned est;
		int unsigned n;
		int unsigned goal;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// two packets with a fast repeat, idle cycle before and after
		c.start_timing = 32'hFFFF_FFFF;
		c.one_timing = 32'hFFFF_0000;
		c.zero_timing = 32'h0000_FFFF;
		c.repeat_timing = 32'h8001_7FFE;
		c.repeat_time = 32'hFFFF_FFFF;
		c.frame_format = {1'b1, 7'd2, 7'd1, 7'd3};
		c.no_stop_bit = 1'b0;
		program_regs(c);
		queue_cycles(1);
		queue_start(32'hFFFF_FFFF, 32'h0);
		queue_cycles(11);
		wait_idle();

		// no middle stop, no stop bit, empty trailer, restart while busy
		c.start_timing = 32'h0;
		c.one_timing = 32'h0001_0001;
		c.zero_timing = 32'h0;
		c.repeat_timing = 32'hFFFF_FFFF;
		c.repeat_time = 32'h0;
		c.frame_format = {1'b0, 7'd0, 7'd0, 7'd2};
		c.no_stop_bit = 1'b1;
		program_regs(c);
		queue_start(32'h0, 32'hFFFF_FFFF);
		queue_cycles(2);
		queue_start(32'hAAAA_AAAA, 32'h5555_5555);
		queue_cycles(4);
		wait_idle();

		// every register at its top value, then a full-length packet
		c = '1;
		program_regs(c);
		queue_cycles(2);
		wait_idle();
		c.frame_format = {1'b1, 7'd2, 7'd0, 7'd127};
		program_regs(c);
		queue_start($urandom, $urandom);
		queue_cycles(133);
		wait_idle();

		// everything zero: bit count wraps all the way round
		c = '0;
		send_quiet = 1'b1;
		program_regs(c);
		queue_start($urandom, $urandom);
		queue_cycles(133);
		wait_idle();

		repeat (3) begin
			send_quiet = ($urandom_range(0, 3) == 0);
			recv_quiet = ($urandom_range(0, 3) == 0);
			c.start_timing = draw_timing();
			c.one_timing = draw_timing();
			c.zero_timing = draw_timing();
			c.repeat_timing = draw_timing();
			case ($urandom_range(0, 2))
				0: c.repeat_time = $urandom;
				1: c.repeat_time = $urandom_range(0, 200000);
				default: c.repeat_time = 32'h0;
			endcase
			len = $urandom_range(1, 16);
			mid = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, len);
			reps = $urandom_range(0, 3);
			c.frame_format = {1'($urandom_range(0, 1)), 7'(reps), 7'(mid), 7'(len)};
			c.no_stop_bit = 1'($urandom_range(0, 1));
			program_regs(c);
			pk = (reps == 0) ? 1 : reps;
			est = len + 4 + (pk - 1) * (c.frame_format[21] ? 3 : len + 4);
			goal = 0;
			while (goal < 45) begin
				if ($urandom_range(0, 5) == 0) begin
					queue_noise();
					goal++;
				end else begin
					n = est + $urandom_range(0, 2);
					if ($urandom_range(0, 5) == 0)
						n = $urandom_range(0, est);
					queue_start($urandom, $urandom);
					queue_cycles(n);
					goal += n + 1;
				end
			end
			queue_start($urandom, $urandom);
			queue_cycles(est + 1);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("%0d requests sent, %0d results checked across %0d register settings",
			n_req, n_res, n_settings);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("ir_remote_frame_sequencer_tb passed");
		else
			$display("ir_remote_frame_sequencer_tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/irfs_pkg.sv
hdl/irfs_regs.sv
hdl/irfs_core.sv
hdl/ir_remote_frame_sequencer.sv
test/ir_remote_frame_sequencer_tb.sv
